// ----- rtl/rkst_pkg.sv -----
// Package for the refcounted key slot table: parameter defaults, codes and beat types.
`timescale 1ns / 1ps
package rkst_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int KEY_WIDTH_DEF  = 32;
    localparam int REF_WIDTH_DEF  = 7;

    localparam int KEY_IN_W   = 32;
    localparam int SLOT_OUT_W = 6;
    localparam int REFS_OUT_W = 7;

    typedef enum logic {
        OP_OPEN  = 1'b0,
        OP_CLOSE = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_OPEN_OLD    = 3'd0,
        STAT_OPEN_NEW    = 3'd1,
        STAT_FULL        = 3'd2,
        STAT_CLOSE_USED  = 3'd3,
        STAT_CLOSE_FREED = 3'd4,
        STAT_NOT_FOUND   = 3'd5,
        STAT_BAD         = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [KEY_IN_W-1:0]   key;
    } in_beat_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [REFS_OUT_W-1:0] refs_after;
    } out_beat_t;

endpackage

// ----- rtl/rkst_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rkst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/refcounted_key_slot_table.sv -----
// Top level: reference-counted keyed slot table with a sequential scan over one RAM.
//
// Input channel s_*: one beat carries an opcode (open/close) and a key. Key 0 is
// rejected. Output channel m_*: one beat per request with status, slot index and
// the slot's reference count after the request.
// Every slot holds {key, count} in one RAM word; a zero key marks a free slot.
// A request with a nonzero key reads all SLOT_COUNT slots, one per cycle, noting the
// first match and the first free slot, then writes back at most one word.
// A new request is taken only in idle, after the previous one has left write-back;
// its scan walks the single RAM read port.
// Reset: a clearing pass writes zero to every slot, with s_ready low.
// Stall: the result sits in an output register; the next request is taken while
// it waits, and its own write-back and result hold until m_ready frees the register.
`timescale 1ns / 1ps
module refcounted_key_slot_table #(
    parameter int SLOT_COUNT = rkst_pkg::SLOT_COUNT_DEF,
    parameter int KEY_WIDTH  = rkst_pkg::KEY_WIDTH_DEF,
    parameter int REF_WIDTH  = rkst_pkg::REF_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rkst_pkg::in_beat_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rkst_pkg::out_beat_t m_data
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int ENT_W  = KEY_WIDTH + REF_WIDTH;
    localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [REF_WIDTH-1:0] REF_MAX   = {REF_WIDTH{1'b1}};
    localparam logic [REF_WIDTH-1:0] REF_ONE   = REF_WIDTH'(1);

    rkst_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0]    clr_reg;
    logic [SLOT_W-1:0]    issue_reg;
    logic                 rvalid_reg;
    logic [SLOT_W-1:0]    ridx_reg;
    rkst_pkg::opcode_t    op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 bad_reg;
    logic                 hit_found_reg;
    logic [SLOT_W-1:0]    hit_idx_reg;
    logic [REF_WIDTH-1:0] hit_refs_reg;
    logic                 free_found_reg;
    logic [SLOT_W-1:0]    free_idx_reg;
    logic                 m_valid_reg;
    rkst_pkg::out_beat_t  m_data_reg;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [REF_WIDTH-1:0] rd_refs;

    logic [KEY_WIDTH+rkst_pkg::KEY_IN_W-1:0] key_ext;
    logic [KEY_WIDTH-1:0] key_in;
    logic                 accept;
    logic                 out_load;

    rkst_pkg::status_t    fin_status;
    logic [SLOT_W-1:0]    fin_slot;
    logic [REF_WIDTH-1:0] fin_refs;
    logic                 fin_we;
    logic [SLOT_W-1:0]    fin_addr;
    logic [ENT_W-1:0]     fin_wdata;
    logic [SLOT_W+rkst_pkg::SLOT_OUT_W-1:0]    slot_ext;
    logic [REF_WIDTH+rkst_pkg::REFS_OUT_W-1:0] refs_ext;

    rkst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_reg),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[ENT_W-1:REF_WIDTH];
    assign rd_refs = ram_rdata[REF_WIDTH-1:0];

    // key input masked or zero-extended to KEY_WIDTH
    assign key_ext = {{KEY_WIDTH{1'b0}}, s_data.key};
    assign key_in  = key_ext[KEY_WIDTH-1:0];

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == rkst_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Outcome of the request once the scan is done.
    always_comb begin
        fin_status = rkst_pkg::STAT_BAD;
        fin_slot   = '0;
        fin_refs   = '0;
        fin_we     = 1'b0;
        fin_addr   = hit_idx_reg;
        fin_wdata  = {key_reg, REF_ONE};
        if (bad_reg) begin
            fin_status = rkst_pkg::STAT_BAD;
        end else if (op_reg == rkst_pkg::OP_OPEN) begin
            if (hit_found_reg) begin
                fin_slot = hit_idx_reg;
                if (hit_refs_reg == REF_MAX) begin
                    fin_status = rkst_pkg::STAT_BAD;
                    fin_refs   = hit_refs_reg;
                end else begin
                    fin_status = rkst_pkg::STAT_OPEN_OLD;
                    fin_refs   = hit_refs_reg + REF_ONE;
                    fin_we     = 1'b1;
                    fin_wdata  = {key_reg, hit_refs_reg + REF_ONE};
                end
            end else if (free_found_reg) begin
                fin_status = rkst_pkg::STAT_OPEN_NEW;
                fin_slot   = free_idx_reg;
                fin_refs   = REF_ONE;
                fin_we     = 1'b1;
                fin_addr   = free_idx_reg;
                fin_wdata  = {key_reg, REF_ONE};
            end else begin
                fin_status = rkst_pkg::STAT_FULL;
            end
        end else begin
            if (!hit_found_reg) begin
                fin_status = rkst_pkg::STAT_NOT_FOUND;
            end else if (hit_refs_reg <= REF_ONE) begin
                fin_status = rkst_pkg::STAT_CLOSE_FREED;
                fin_slot   = hit_idx_reg;
                fin_we     = 1'b1;
                fin_wdata  = '0;
            end else begin
                fin_status = rkst_pkg::STAT_CLOSE_USED;
                fin_slot   = hit_idx_reg;
                fin_refs   = hit_refs_reg - REF_ONE;
                fin_we     = 1'b1;
                fin_wdata  = {key_reg, hit_refs_reg - REF_ONE};
            end
        end
    end

    assign slot_ext = {{rkst_pkg::SLOT_OUT_W{1'b0}}, fin_slot};
    assign refs_ext = {{rkst_pkg::REFS_OUT_W{1'b0}}, fin_refs};

    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = clr_reg;
        ram_wdata  = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            rkst_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                if (clr_reg == LAST_SLOT) begin
                    state_next = rkst_pkg::ST_IDLE;
                end
            end
            rkst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (key_in == '0) ? rkst_pkg::ST_FINISH : rkst_pkg::ST_SCAN;
                end
            end
            rkst_pkg::ST_SCAN: begin
                if (issue_reg == LAST_SLOT) begin
                    state_next = rkst_pkg::ST_DRAIN;
                end
            end
            rkst_pkg::ST_DRAIN: begin
                state_next = rkst_pkg::ST_FINISH;
            end
            rkst_pkg::ST_FINISH: begin
                // writes land only after the whole scan, so no read can see stale data
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    ram_we     = fin_we;
                    ram_waddr  = fin_addr;
                    ram_wdata  = fin_wdata;
                    state_next = rkst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rkst_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rkst_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg        <= '0;
            rvalid_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (state_reg == rkst_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            rvalid_reg <= (state_reg == rkst_pkg::ST_SCAN);
            if (accept) begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (rvalid_reg) begin
                if (!hit_found_reg && rd_key == key_reg) begin
                    hit_found_reg <= 1'b1;
                end
                if (!free_found_reg && rd_key == '0) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        ridx_reg <= issue_reg;
        if (accept) begin
            op_reg    <= s_data.opcode;
            key_reg   <= key_in;
            bad_reg   <= (key_in == '0);
            issue_reg <= '0;
        end else if (state_reg == rkst_pkg::ST_SCAN) begin
            issue_reg <= issue_reg + 1'b1;
        end
        if (rvalid_reg && !hit_found_reg && rd_key == key_reg) begin
            hit_idx_reg  <= ridx_reg;
            hit_refs_reg <= rd_refs;
        end
        if (rvalid_reg && !free_found_reg && rd_key == '0) begin
            free_idx_reg <= ridx_reg;
        end
        if (out_load) begin
            m_data_reg.status     <= fin_status;
            m_data_reg.slot       <= slot_ext[rkst_pkg::SLOT_OUT_W-1:0];
            m_data_reg.refs_after <= refs_ext[rkst_pkg::REFS_OUT_W-1:0];
        end
    end

    // RAM is written only by the clearing pass or the write-back of a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == rkst_pkg::ST_CLEAR || state_reg == rkst_pkg::ST_FINISH))
        else $error("RAM write outside clear or write-back");

    // An accepted request goes to the scan, or straight to write-back for a zero key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == rkst_pkg::ST_SCAN || state_reg == rkst_pkg::ST_FINISH))
        else $error("accepted request did not start");

    // A matched slot always carries a nonzero count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rkst_pkg::ST_FINISH && hit_found_reg) |-> (hit_refs_reg != '0))
        else $error("matched slot with zero count");

    // A new allocation only happens when no slot matched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && fin_status == rkst_pkg::STAT_OPEN_NEW) |-> (!hit_found_reg && free_found_reg))
        else $error("new slot allocated despite match");

    // Result register is never overwritten while it holds an untaken beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("pending result beat overwritten");

endmodule

// ----- bench/tb_refcounted_key_slot_table.sv -----
// Self-checking testbench for the refcounted key slot table: directed and random open/close beats.
`timescale 1ns / 1ps
module tb_refcounted_key_slot_table;

    localparam int SLOTS      = rkst_pkg::SLOT_COUNT_DEF;
    localparam int REF_MAX    = (1 << rkst_pkg::REF_WIDTH_DEF) - 1;
    localparam int POOL_KEYS  = 24;
    localparam int FILL_KEYS  = SLOTS + 4;
    localparam int PHASE_BEATS = 530;
    localparam int MAX_PRINTED = 50;
    localparam logic [rkst_pkg::REF_WIDTH_DEF-1:0] REF_ONE =
        {{(rkst_pkg::REF_WIDTH_DEF-1){1'b0}}, 1'b1};

    // Shadow copy of the table; predicts one result beat per accepted request.
    class segment_table_tracker;
        logic [rkst_pkg::KEY_IN_W-1:0]      keys [SLOTS];
        logic [rkst_pkg::REF_WIDTH_DEF-1:0] refs [SLOTS];
        rkst_pkg::out_beat_t                outstanding [$];
        int                                 mismatches;
        int                                 checked;
        int                                 status_hits [7];

        function new();
            foreach (keys[i]) begin
                keys[i] = '0;
                refs[i] = '0;
            end
            mismatches = 0;
            checked = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function int find_slot(logic [rkst_pkg::KEY_IN_W-1:0] k);
            for (int i = 0; i < SLOTS; i++) begin
                if (keys[i] == k) return i;
            end
            return -1;
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        function void note_request(rkst_pkg::in_beat_t req);
            rkst_pkg::out_beat_t res;
            int                  hit;
            int                  spare;
            res.status = rkst_pkg::STAT_BAD;
            res.slot = '0;
            res.refs_after = '0;
            if (req.key != '0) begin
                hit = find_slot(req.key);
                if (req.opcode == rkst_pkg::OP_OPEN) begin
                    if (hit >= 0) begin
                        res.slot = rkst_pkg::SLOT_OUT_W'(hit);
                        if (refs[hit] == REF_MAX) begin
                            // count saturated: rejected, state untouched
                            res.status = rkst_pkg::STAT_BAD;
                        end else begin
                            refs[hit] = refs[hit] + 1'b1;
                            res.status = rkst_pkg::STAT_OPEN_OLD;
                        end
                        res.refs_after = refs[hit];
                    end else begin
                        spare = find_slot('0);
                        if (spare < 0) begin
                            res.status = rkst_pkg::STAT_FULL;
                        end else begin
                            keys[spare] = req.key;
                            refs[spare] = REF_ONE;
                            res.status = rkst_pkg::STAT_OPEN_NEW;
                            res.slot = rkst_pkg::SLOT_OUT_W'(spare);
                            res.refs_after = REF_ONE;
                        end
                    end
                end else if (hit < 0) begin
                    res.status = rkst_pkg::STAT_NOT_FOUND;
                end else if (refs[hit] <= REF_ONE) begin
                    keys[hit] = '0;
                    refs[hit] = '0;
                    res.status = rkst_pkg::STAT_CLOSE_FREED;
                    res.slot = rkst_pkg::SLOT_OUT_W'(hit);
                end else begin
                    refs[hit] = refs[hit] - 1'b1;
                    res.status = rkst_pkg::STAT_CLOSE_USED;
                    res.slot = rkst_pkg::SLOT_OUT_W'(hit);
                    res.refs_after = refs[hit];
                end
            end
            outstanding.push_back(res);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED) $display("mismatch @%0t: %s", $time, msg);
        endtask

        task check_result(rkst_pkg::out_beat_t got);
            rkst_pkg::out_beat_t want;
            if (outstanding.size() == 0) begin
                report($sformatf("unexpected beat status %0d slot %0d refs %0d",
                                 got.status, got.slot, got.refs_after));
                return;
            end
            want = outstanding.pop_front();
            checked++;
            status_hits[int'(want.status)]++;
            if (got.status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 checked, got.status, want.status));
            if (got.slot !== want.slot)
                report($sformatf("result %0d slot %0d, want %0d",
                                 checked, got.slot, want.slot));
            if (got.refs_after !== want.refs_after)
                report($sformatf("result %0d refs_after %0d, want %0d",
                                 checked, got.refs_after, want.refs_after));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    rkst_pkg::in_beat_t   s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    rkst_pkg::out_beat_t  m_data;

    segment_table_tracker board;
    int                   send_idle_pct = 24;
    int                   recv_idle_pct = 88;
    int                   beats_sent = 0;
    logic [rkst_pkg::KEY_IN_W-1:0] pool_keys [POOL_KEYS];

    refcounted_key_slot_table uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // One request beat; valid holds with a stable payload until accepted.
    task automatic send_request(input rkst_pkg::opcode_t op,
                                input logic [rkst_pkg::KEY_IN_W-1:0] key);
        rkst_pkg::in_beat_t beat;
        beat.opcode = op;
        beat.key = key;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        board.note_request(beat);
        beats_sent++;
    endtask

    // More fresh keys than slots: runs the table full, then releases them all.
    task automatic run_fill();
        logic [rkst_pkg::KEY_IN_W-1:0] fresh [FILL_KEYS];
        bit                            backward;
        backward = $urandom_range(0, 1);
        for (int i = 0; i < FILL_KEYS; i++) begin
            fresh[i] = $urandom();
            send_request(rkst_pkg::OP_OPEN, fresh[i]);
        end
        for (int i = 0; i < FILL_KEYS; i++)
            send_request(rkst_pkg::OP_CLOSE, fresh[backward ? FILL_KEYS - 1 - i : i]);
    endtask

    // Drive one key past its maximum count, then close it past zero.
    task automatic run_saturate();
        logic [rkst_pkg::KEY_IN_W-1:0] key;
        key = $urandom();
        repeat (REF_MAX + 3) send_request(rkst_pkg::OP_OPEN, key);
        repeat (REF_MAX + 2) send_request(rkst_pkg::OP_CLOSE, key);
    endtask

    initial begin
        int pick;
        int len;
        int drain;
        board = new();
        foreach (pool_keys[i]) pool_keys[i] = $urandom();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reserved key, miss, reuse of the lowest free slot, field extremes
        send_request(rkst_pkg::OP_OPEN,  32'h0000_0000);
        send_request(rkst_pkg::OP_CLOSE, 32'h0000_0000);
        send_request(rkst_pkg::OP_CLOSE, 32'hFFFF_FFFF);
        send_request(rkst_pkg::OP_OPEN,  32'hFFFF_FFFF);
        send_request(rkst_pkg::OP_OPEN,  32'hFFFF_FFFF);
        send_request(rkst_pkg::OP_OPEN,  32'h0000_0001);
        send_request(rkst_pkg::OP_OPEN,  32'h8000_0000);
        send_request(rkst_pkg::OP_CLOSE, 32'hFFFF_FFFF);
        send_request(rkst_pkg::OP_CLOSE, 32'hFFFF_FFFF);
        send_request(rkst_pkg::OP_OPEN,  32'h7FFF_FFFF);
        send_request(rkst_pkg::OP_CLOSE, 32'h0000_0001);
        send_request(rkst_pkg::OP_CLOSE, 32'h0000_0001);
        send_request(rkst_pkg::OP_OPEN,  32'hAAAA_AAAA);
        send_request(rkst_pkg::OP_OPEN,  32'h5555_5555);
        send_request(rkst_pkg::OP_CLOSE, 32'h8000_0000);
        send_request(rkst_pkg::OP_CLOSE, 32'hAAAA_AAAA);
        send_request(rkst_pkg::OP_CLOSE, 32'h5555_5555);
        send_request(rkst_pkg::OP_CLOSE, 32'h7FFF_FFFF);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            run_fill();
            if (phase == 0) run_saturate();
            while (beats_sent < (phase + 1) * PHASE_BEATS) begin
                pick = $urandom_range(0, 99);
                if (pick < 74) begin
                    // working set of keys, mostly well-formed open/close traffic
                    len = $urandom_range(6, 20);
                    repeat (len) begin
                        send_request(($urandom_range(0, 99) < 55) ? rkst_pkg::OP_OPEN
                                                                  : rkst_pkg::OP_CLOSE,
                                     ($urandom_range(0, 19) == 0) ? 32'd0
                                         : pool_keys[$urandom_range(0, POOL_KEYS - 1)]);
                    end
                end else if (pick < 86) begin
                    len = $urandom_range(3, 10);
                    repeat (len) begin
                        send_request(rkst_pkg::opcode_t'($urandom_range(0, 1)),
                                     ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom());
                    end
                end else if (pick < 96) begin
                    run_fill();
                end else begin
                    run_saturate();
                end
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        drain = 0;
        while (board.pending() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SLOTS + 8) @(posedge aclk);

        $display("summary: %0d requests, %0d results checked under three stall mixes",
                 beats_sent, board.checked);
        $display("summary: old %0d new %0d full %0d used %0d freed %0d miss %0d reject %0d",
                 board.status_hits[0], board.status_hits[1], board.status_hits[2],
                 board.status_hits[3], board.status_hits[4], board.status_hits[5],
                 board.status_hits[6]);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            if (board.pending() != 0)
                $display("%0d results never arrived", board.pending());
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: fails the run if the requests have not all completed by the timeout.
    initial begin
        #2_000_000;
        $display("timeout waiting on the table");
        $display("status: fail");
        $finish;
    end

endmodule
